// ----- design/hrp_pkg.sv -----
// ----------------------------------------------------------------------------
// hrp_pkg: shared types, constants and helpers of the HTTP request parser
// Character codes, result codes, queue sizing and byte classification.
// ----------------------------------------------------------------------------
package hrp_pkg;

    localparam int LEN_W       = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int NAME_LEN    = 14;
    localparam int NAME_IDX_W  = 4;
    localparam int VER_W       = 16;

    localparam logic [LEN_W-1:0] LEN_MAX = '1;
    localparam logic [VER_W-1:0] VER_MAX = '1;

    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CTL_MAX  = 8'h1F;

    // status codes
    localparam logic [1:0] ST_MORE = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    // byte class codes
    localparam logic [2:0] CLS_DELIM = 3'd0;
    localparam logic [2:0] CLS_METH  = 3'd1;
    localparam logic [2:0] CLS_URI   = 3'd2;
    localparam logic [2:0] CLS_HNAME = 3'd3;
    localparam logic [2:0] CLS_HVAL  = 3'd4;
    localparam logic [2:0] CLS_BODY  = 3'd5;

    // classified input word
    typedef struct packed {
        logic [7:0] data;
        logic       restart;
        logic       tok;
        logic       ctl;
        logic       dig;
    } t_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [2:0]       cls;
        logic             hb;
        logic [VER_W-1:0] maj;
        logic [VER_W-1:0] min;
        logic [31:0]      len;
    } t_result;

    function automatic logic is_ctl(input logic [7:0] c);
        return (c <= CTL_MAX) || (c == CH_DEL);
    endfunction

    function automatic logic is_token(input logic [7:0] c);
        logic special;
        special = c inside {8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A,
                            8'h5C, 8'h22, 8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B,
                            8'h7D, 8'h20, 8'h09};
        return !c[7] && !is_ctl(c) && !special;
    endfunction

    function automatic logic is_dec_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    // "Content-Length"
    function automatic logic [7:0] name_char(input logic [NAME_IDX_W-1:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h43;
            4'd1:    ch = 8'h6F;
            4'd2:    ch = 8'h6E;
            4'd3:    ch = 8'h74;
            4'd4:    ch = 8'h65;
            4'd5:    ch = 8'h6E;
            4'd6:    ch = 8'h74;
            4'd7:    ch = 8'h2D;
            4'd8:    ch = 8'h4C;
            4'd9:    ch = 8'h65;
            4'd10:   ch = 8'h6E;
            4'd11:   ch = 8'h67;
            4'd12:   ch = 8'h74;
            4'd13:   ch = 8'h68;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // 10*v + d, saturating; 10v+d > max is the overflow test
    function automatic logic [LEN_W-1:0] len_acc(input logic [LEN_W-1:0] v,
                                                 input logic [3:0] d);
        logic [LEN_W+3:0] x;
        x = ({4'b0, v} << 3) + ({4'b0, v} << 1) + (LEN_W+4)'(d);
        if (x > {4'b0, LEN_MAX}) return LEN_MAX;
        return x[LEN_W-1:0];
    endfunction

    function automatic logic [VER_W-1:0] ver_acc(input logic [VER_W-1:0] v,
                                                 input logic [3:0] d);
        logic [VER_W+3:0] x;
        x = ({4'b0, v} << 3) + ({4'b0, v} << 1) + (VER_W+4)'(d);
        if (x > {4'b0, VER_MAX}) return VER_MAX;
        return x[VER_W-1:0];
    endfunction

    function automatic logic [31:0] len_out(input logic [LEN_W-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[31:0];
    endfunction

endpackage

// ----- design/http_request_parser_unit.sv -----
// ----------------------------------------------------------------------------
// http_request_parser_unit: HTTP/1.x request parser, one byte per word
// Path: each accepted byte is stored in the queue, then parsed into the result register.
// Throughput: 1 byte per cycle while the output does not stall the parser state machine.
// A 4-word queue decouples the input from the result register.
// Reset (synchronous, active low) clears parser state and queue; no sweep.
// ----------------------------------------------------------------------------
module http_request_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] restart
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata    // status, byte_class, header_begin,
                                        // version_major, version_minor,
                                        // body_length, zero pad
);

    logic             push, full, q_valid, pop;
    hrp_pkg::t_item   f_item, q_item;
    hrp_pkg::t_result res;

    hrp_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_full        (full),
        .o_push        (push),
        .o_item        (f_item)
    );

    hrp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (pop)
    );

    hrp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_item  (q_item),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .o_res   (res),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = {2'b00, res.len, res.min, res.maj, res.hb, res.cls, res.status};

endmodule

// ----- design/hrp_front.sv -----
// ----------------------------------------------------------------------------
// hrp_front: input side of the request parser
// Takes request bytes, tags them with character class flags, pushes words.
// ----------------------------------------------------------------------------
module hrp_front (
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // data_byte
    input  logic [0:0]    s_axis_tuser,   // restart
    input  logic          i_full,
    output logic          o_push,
    output hrp_pkg::t_item o_item
);

    assign s_axis_tready = !i_full;
    assign o_push        = s_axis_tvalid && !i_full;

    always_comb begin
        o_item.data    = s_axis_tdata;
        o_item.restart = s_axis_tuser[0];
        o_item.tok     = hrp_pkg::is_token(s_axis_tdata);
        o_item.ctl     = hrp_pkg::is_ctl(s_axis_tdata);
        o_item.dig     = hrp_pkg::is_dec_digit(s_axis_tdata);
    end

endmodule

// ----- design/hrp_queue.sv -----
// ----------------------------------------------------------------------------
// hrp_queue: short word queue between classifier and parser
// Register file with read and write pointers and an occupancy count.
// ----------------------------------------------------------------------------
module hrp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hrp_pkg::t_item i_item,
    output logic           o_full,
    output logic           o_valid,
    output hrp_pkg::t_item o_item,
    input  logic           i_pop
);

    hrp_pkg::t_item r_mem [hrp_pkg::QUEUE_DEPTH];
    logic [hrp_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [hrp_pkg::QCNT_W-1:0] r_count;

    assign o_full  = (r_count == hrp_pkg::QCNT_W'(hrp_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (!i_push && i_pop) r_count <= r_count - 1'b1;
        end
    end

endmodule

// ----- design/hrp_back.sv -----
// ----------------------------------------------------------------------------
// hrp_back: request parser state machine and result register
// Walks the request line, headers and body; one word per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module hrp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  hrp_pkg::t_item   i_item,
    output logic             o_pop,
    output logic             o_valid,
    output hrp_pkg::t_result o_res,
    input  logic             i_ready
);

    typedef enum logic [20:0] {
        PH_MSTART = 21'h000001,
        PH_METHOD = 21'h000002,
        PH_URI    = 21'h000004,
        PH_H      = 21'h000008,
        PH_T1     = 21'h000010,
        PH_T2     = 21'h000020,
        PH_P      = 21'h000040,
        PH_SLASH  = 21'h000080,
        PH_MAJ0   = 21'h000100,
        PH_MAJ    = 21'h000200,
        PH_MIN0   = 21'h000400,
        PH_MIN    = 21'h000800,
        PH_NL1    = 21'h001000,
        PH_LSTART = 21'h002000,
        PH_LWS    = 21'h004000,
        PH_HNAME  = 21'h008000,
        PH_SP     = 21'h010000,
        PH_HVAL   = 21'h020000,
        PH_NL2    = 21'h040000,
        PH_NL3    = 21'h080000,
        PH_BODY   = 21'h100000
    } t_phase;

    typedef enum logic [3:0] {
        NP_SKIP = 4'b0001,
        NP_SIGN = 4'b0010,
        NP_DIG  = 4'b0100,
        NP_DONE = 4'b1000
    } t_nph;

    localparam int LW = hrp_pkg::LEN_W;
    localparam int VW = hrp_pkg::VER_W;
    localparam int IW = hrp_pkg::NAME_IDX_W;

    t_phase          r_phase, c_phase, n_phase;
    logic [1:0]      r_outcome, c_outcome, n_outcome;
    logic            r_any, c_any, n_any;
    logic [IW-1:0]   r_idx, c_idx, n_idx;
    logic            r_match, c_match, n_match;
    logic            r_len_found, c_len_found, n_len_found;
    logic            r_in_len, c_in_len, n_in_len;
    t_nph            r_np, c_np, n_np;
    logic            r_neg, c_neg, n_neg;
    logic [LW-1:0]   r_len, c_len, n_len;
    logic [LW-1:0]   r_body, c_body, n_body;
    logic [VW-1:0]   r_maj, c_maj, n_maj;
    logic [VW-1:0]   r_min, c_min, n_min;

    t_nph            vb_np;
    logic            vb_neg;
    logic [LW-1:0]   vb_len;
    logic [IW-1:0]   nb_idx;
    logic            nb_match;
    logic            st_match;

    logic [7:0]      c;
    logic [3:0]      dval;
    logic [1:0]      res;
    logic [2:0]      cls;
    logic            hb;
    logic [LW-1:0]   body_inc;

    logic             r_out_valid;
    hrp_pkg::t_result r_res;

    assign o_pop   = i_valid && (!r_out_valid || i_ready);
    assign o_valid = r_out_valid;
    assign o_res   = r_res;
    assign c       = i_item.data;
    assign dval    = 4'(c - hrp_pkg::CH_0);
    assign body_inc = c_body + 1'b1;

    // restart returns to reset values before this word is used
    always_comb begin
        if (i_item.restart) begin
            c_phase = PH_MSTART;  c_outcome = hrp_pkg::ST_MORE;
            c_any = 1'b0;         c_idx = '0;       c_match = 1'b1;
            c_len_found = 1'b0;   c_in_len = 1'b0;  c_np = NP_SKIP;
            c_neg = 1'b0;         c_len = '0;       c_body = '0;
            c_maj = '0;           c_min = '0;
        end else begin
            c_phase = r_phase;    c_outcome = r_outcome;
            c_any = r_any;        c_idx = r_idx;    c_match = r_match;
            c_len_found = r_len_found; c_in_len = r_in_len; c_np = r_np;
            c_neg = r_neg;        c_len = r_len;    c_body = r_body;
            c_maj = r_maj;        c_min = r_min;
        end
    end

    // Content-Length value byte
    always_comb begin
        vb_np  = c_np;
        vb_neg = c_neg;
        vb_len = c_len;
        if (c_in_len) begin
            case (c_np)
                NP_SKIP: begin
                    if (c == hrp_pkg::CH_SP) begin
                        vb_np = NP_SKIP;
                    end else if (c == hrp_pkg::CH_PLUS) begin
                        vb_np = NP_SIGN;
                    end else if (c == hrp_pkg::CH_MINUS) begin
                        vb_neg = 1'b1;
                        vb_np  = NP_DONE;
                    end else if (i_item.dig) begin
                        vb_len = hrp_pkg::len_acc(c_len, dval);
                        vb_np  = NP_DIG;
                    end else begin
                        vb_np = NP_DONE;
                    end
                end
                NP_SIGN, NP_DIG: begin
                    if (i_item.dig) begin
                        vb_len = hrp_pkg::len_acc(c_len, dval);
                        vb_np  = NP_DIG;
                    end else begin
                        vb_np = NP_DONE;
                    end
                end
                default: vb_np = c_np;
            endcase
        end
    end

    // header name matcher; a new line starts from index 0, still matching
    always_comb begin
        logic [IW-1:0] bi;
        logic          bm;
        bi = (c_phase == PH_LSTART) ? '0 : c_idx;
        bm = (c_phase == PH_LSTART) ? 1'b1 : c_match;
        nb_idx   = bi;
        nb_match = bm;
        if (bi < IW'(hrp_pkg::NAME_LEN) && hrp_pkg::name_char(bi) == c) begin
            nb_idx = bi + 1'b1;
        end else begin
            nb_match = 1'b0;
        end
    end

    assign st_match = c_match && (c_idx == IW'(hrp_pkg::NAME_LEN)) && !c_len_found;

    always_comb begin
        n_phase = c_phase;  n_outcome = c_outcome; n_any = c_any;
        n_idx = c_idx;      n_match = c_match;     n_len_found = c_len_found;
        n_in_len = c_in_len; n_np = c_np;          n_neg = c_neg;
        n_len = c_len;      n_body = c_body;       n_maj = c_maj;
        n_min = c_min;
        res = hrp_pkg::ST_MORE;
        cls = hrp_pkg::CLS_DELIM;
        hb  = 1'b0;
        if (c_outcome == hrp_pkg::ST_MORE) begin
            case (c_phase)
                PH_MSTART: begin
                    if (i_item.tok) begin
                        n_phase = PH_METHOD;
                        cls = hrp_pkg::CLS_METH;
                    end else res = hrp_pkg::ST_BAD;
                end
                PH_METHOD: begin
                    if (c == hrp_pkg::CH_SP) n_phase = PH_URI;
                    else if (i_item.tok) cls = hrp_pkg::CLS_METH;
                    else res = hrp_pkg::ST_BAD;
                end
                PH_URI: begin
                    if (c == hrp_pkg::CH_SP) n_phase = PH_H;
                    else if (i_item.ctl) res = hrp_pkg::ST_BAD;
                    else cls = hrp_pkg::CLS_URI;
                end
                PH_H: begin
                    if (c == hrp_pkg::CH_H) n_phase = PH_T1; else res = hrp_pkg::ST_BAD;
                end
                PH_T1: begin
                    if (c == hrp_pkg::CH_T) n_phase = PH_T2; else res = hrp_pkg::ST_BAD;
                end
                PH_T2: begin
                    if (c == hrp_pkg::CH_T) n_phase = PH_P; else res = hrp_pkg::ST_BAD;
                end
                PH_P: begin
                    if (c == hrp_pkg::CH_P) n_phase = PH_SLASH; else res = hrp_pkg::ST_BAD;
                end
                PH_SLASH: begin
                    if (c == hrp_pkg::CH_SLASH) begin
                        n_maj = '0;
                        n_min = '0;
                        n_phase = PH_MAJ0;
                    end else res = hrp_pkg::ST_BAD;
                end
                PH_MAJ0: begin
                    if (i_item.dig) begin
                        n_maj = hrp_pkg::ver_acc(c_maj, dval);
                        n_phase = PH_MAJ;
                    end else res = hrp_pkg::ST_BAD;
                end
                PH_MAJ: begin
                    if (c == hrp_pkg::CH_DOT) n_phase = PH_MIN0;
                    else if (i_item.dig) n_maj = hrp_pkg::ver_acc(c_maj, dval);
                    else res = hrp_pkg::ST_BAD;
                end
                PH_MIN0: begin
                    if (i_item.dig) begin
                        n_min = hrp_pkg::ver_acc(c_min, dval);
                        n_phase = PH_MIN;
                    end else res = hrp_pkg::ST_BAD;
                end
                PH_MIN: begin
                    if (c == hrp_pkg::CH_CR) n_phase = PH_NL1;
                    else if (i_item.dig) n_min = hrp_pkg::ver_acc(c_min, dval);
                    else res = hrp_pkg::ST_BAD;
                end
                PH_NL1: begin
                    if (c == hrp_pkg::CH_LF) n_phase = PH_LSTART; else res = hrp_pkg::ST_BAD;
                end
                PH_LSTART: begin
                    if (c == hrp_pkg::CH_CR) begin
                        n_phase = PH_NL3;
                    end else if (c_any && (c == hrp_pkg::CH_SP || c == hrp_pkg::CH_HT)) begin
                        n_phase = PH_LWS;
                    end else if (!i_item.tok) begin
                        res = hrp_pkg::ST_BAD;
                    end else begin
                        n_any    = 1'b1;
                        n_in_len = 1'b0;
                        n_idx    = nb_idx;
                        n_match  = nb_match;
                        n_phase  = PH_HNAME;
                        cls = hrp_pkg::CLS_HNAME;
                        hb  = 1'b1;
                    end
                end
                PH_LWS: begin
                    if (c == hrp_pkg::CH_CR) begin
                        n_phase = PH_NL2;
                    end else if (c == hrp_pkg::CH_SP || c == hrp_pkg::CH_HT) begin
                        n_phase = PH_LWS;
                    end else if (i_item.ctl) begin
                        res = hrp_pkg::ST_BAD;
                    end else begin
                        n_phase = PH_HVAL;
                        n_np = vb_np; n_neg = vb_neg; n_len = vb_len;
                        cls = hrp_pkg::CLS_HVAL;
                    end
                end
                PH_HNAME: begin
                    if (c == hrp_pkg::CH_COLON) begin
                        if (st_match) begin
                            n_len_found = 1'b1;
                            n_in_len    = 1'b1;
                            n_np        = NP_SKIP;
                        end
                        n_phase = PH_SP;
                    end else if (i_item.tok) begin
                        n_idx   = nb_idx;
                        n_match = nb_match;
                        cls = hrp_pkg::CLS_HNAME;
                    end else res = hrp_pkg::ST_BAD;
                end
                PH_SP: begin
                    if (c == hrp_pkg::CH_SP) n_phase = PH_HVAL; else res = hrp_pkg::ST_BAD;
                end
                PH_HVAL: begin
                    if (c == hrp_pkg::CH_CR) begin
                        n_phase = PH_NL2;
                    end else if (i_item.ctl) begin
                        res = hrp_pkg::ST_BAD;
                    end else begin
                        n_np = vb_np; n_neg = vb_neg; n_len = vb_len;
                        cls = hrp_pkg::CLS_HVAL;
                    end
                end
                PH_NL2: begin
                    if (c == hrp_pkg::CH_LF) n_phase = PH_LSTART; else res = hrp_pkg::ST_BAD;
                end
                PH_NL3: begin
                    if (c != hrp_pkg::CH_LF || c_neg) begin
                        res = hrp_pkg::ST_BAD;
                    end else if (c_len != '0) begin
                        n_body  = '0;
                        n_phase = PH_BODY;
                    end else res = hrp_pkg::ST_DONE;
                end
                PH_BODY: begin
                    cls    = hrp_pkg::CLS_BODY;
                    n_body = body_inc;
                    if (body_inc == c_len) res = hrp_pkg::ST_DONE;
                end
                default: res = hrp_pkg::ST_BAD;
            endcase
            if (res == hrp_pkg::ST_BAD) begin
                cls = hrp_pkg::CLS_DELIM;
                hb  = 1'b0;
            end
            n_outcome = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MSTART;  r_outcome <= hrp_pkg::ST_MORE;
            r_any <= 1'b0;         r_idx <= '0;       r_match <= 1'b1;
            r_len_found <= 1'b0;   r_in_len <= 1'b0;  r_np <= NP_SKIP;
            r_neg <= 1'b0;         r_len <= '0;       r_body <= '0;
            r_maj <= '0;           r_min <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase <= n_phase;    r_outcome <= n_outcome;
                r_any <= n_any;        r_idx <= n_idx;    r_match <= n_match;
                r_len_found <= n_len_found; r_in_len <= n_in_len; r_np <= n_np;
                r_neg <= n_neg;        r_len <= n_len;    r_body <= n_body;
                r_maj <= n_maj;        r_min <= n_min;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res.status <= n_outcome;
            r_res.cls    <= cls;
            r_res.hb     <= hb;
            r_res.maj    <= n_maj;
            r_res.min    <= n_min;
            r_res.len    <= hrp_pkg::len_out(n_len);
        end
    end

`ifndef ASSERT_OFF
    a_outcome_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outcome == hrp_pkg::ST_MORE || r_outcome == hrp_pkg::ST_DONE ||
        r_outcome == hrp_pkg::ST_BAD)
        else $error("outcome register holds an unused code");

    a_hb_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.hb |-> r_res.cls == hrp_pkg::CLS_HNAME)
        else $error("header start flagged outside a header name");

    a_bad_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.status == hrp_pkg::ST_BAD |-> r_res.cls == hrp_pkg::CLS_DELIM)
        else $error("invalid word carries a field class");

    a_len_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_len_found |-> !r_in_len)
        else $error("length header active before one was found");

    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && !i_item.restart && r_outcome != hrp_pkg::ST_MORE
        |=> r_outcome == $past(r_outcome))
        else $error("final outcome changed without restart");
`endif

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stream-level check of the HTTP request parser
// Feeds request bytes, some well-formed with random content, some mangled,
// through the input stream with random gaps and output stalls. Every result
// word is compared field by field against a byte-level model of the parser.
// ----------------------------------------------------------------------------
module testbench;
    import hrp_pkg::*;

    localparam int ITEMS       = 1850;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SHOW_MAX    = 10;

    typedef enum logic [4:0] {
        P_MSTART, P_METHOD, P_URI, P_H, P_T1, P_T2, P_P, P_SLASH,
        P_MAJ0, P_MAJ, P_MIN0, P_MIN, P_NL1, P_LSTART, P_LWS,
        P_HNAME, P_SP, P_HVAL, P_NL2, P_NL3, P_BODY
    } parse_phase_e;

    typedef enum logic [1:0] {N_LEAD, N_SIGNED, N_DIGITS, N_STOP} number_phase_e;

    class request_scoreboard;
        parse_phase_e     phase;
        logic [1:0]       outcome;
        bit               any_hdr;
        int unsigned      name_idx;
        bit               name_ok;
        bit               len_found;
        bit               in_len;
        number_phase_e    num_state;
        bit               len_neg;
        logic [LEN_W-1:0] len_val;
        logic [LEN_W-1:0] body_cnt;
        logic [VER_W-1:0] ver_major;
        logic [VER_W-1:0] ver_minor;
        t_result          due_results[$];
        int               errors;

        function new();
            clear();
            errors = 0;
        endfunction

        function void clear();
            phase     = P_MSTART;
            outcome   = ST_MORE;
            any_hdr   = 0;
            name_idx  = 0;
            name_ok   = 1;
            len_found = 0;
            in_len    = 0;
            num_state = N_LEAD;
            len_neg   = 0;
            len_val   = '0;
            body_cnt  = '0;
            ver_major = '0;
            ver_minor = '0;
        endfunction

        static function bit ctl_char(logic [7:0] c);
            return (c <= 8'h1F) || (c == CH_DEL);
        endfunction

        static function bit digit_char(logic [7:0] c);
            return (c >= CH_0) && (c <= CH_9);
        endfunction

        static function bit tok_char(logic [7:0] c);
            bit sep;
            case (c)
                8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C,
                8'h22, 8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h20,
                8'h09:   sep = 1;
                default: sep = 0;
            endcase
            return (c < 8'h80) && !ctl_char(c) && !sep;
        endfunction

        static function logic [7:0] cl_char(int unsigned i);
            logic [8*NAME_LEN-1:0] s;
            s = "Content-Length";
            return s[8*(NAME_LEN-1-i) +: 8];
        endfunction

        static function logic [VER_W-1:0] ver_step(logic [VER_W-1:0] v, logic [7:0] c);
            logic [VER_W+3:0] x;
            x = (VER_W+4)'(v) * 10 + (VER_W+4)'(c - CH_0);
            return (x > (VER_W+4)'(VER_MAX)) ? VER_MAX : x[VER_W-1:0];
        endfunction

        static function logic [LEN_W-1:0] len_step(logic [LEN_W-1:0] v, logic [7:0] c);
            logic [LEN_W+3:0] x;
            x = (LEN_W+4)'(v) * 10 + (LEN_W+4)'(c - CH_0);
            return (x > (LEN_W+4)'(LEN_MAX)) ? LEN_MAX : x[LEN_W-1:0];
        endfunction

        function void name_step(logic [7:0] c);
            if (name_idx < NAME_LEN && cl_char(name_idx) == c) begin
                name_idx++;
            end else begin
                name_ok = 0;
            end
        endfunction

        // Content-Length value: spaces, optional sign, digits, stop at anything else
        function void value_step(logic [7:0] c);
            if (!in_len) return;
            case (num_state)
                N_LEAD: begin
                    if (c != CH_SP) begin
                        if (c == CH_PLUS) begin
                            num_state = N_SIGNED;
                        end else if (c == CH_MINUS) begin
                            len_neg   = 1;
                            num_state = N_STOP;
                        end else if (digit_char(c)) begin
                            len_val   = len_step(len_val, c);
                            num_state = N_DIGITS;
                        end else begin
                            num_state = N_STOP;
                        end
                    end
                end
                N_SIGNED, N_DIGITS: begin
                    if (digit_char(c)) begin
                        len_val   = len_step(len_val, c);
                        num_state = N_DIGITS;
                    end else begin
                        num_state = N_STOP;
                    end
                end
                default: ;
            endcase
        endfunction

        function void note_byte(logic [7:0] c, logic rs);
            logic [2:0] cls;
            logic       hb;
            logic [1:0] res;
            t_result    r;
            cls = CLS_DELIM;
            hb  = 0;
            res = ST_MORE;
            if (rs) clear();
            if (outcome == ST_MORE) begin
                case (phase)
                    P_MSTART: begin
                        if (tok_char(c)) begin
                            phase = P_METHOD;
                            cls   = CLS_METH;
                        end else res = ST_BAD;
                    end
                    P_METHOD: begin
                        if (c == CH_SP) phase = P_URI;
                        else if (tok_char(c)) cls = CLS_METH;
                        else res = ST_BAD;
                    end
                    P_URI: begin
                        if (c == CH_SP) phase = P_H;
                        else if (ctl_char(c)) res = ST_BAD;
                        else cls = CLS_URI;
                    end
                    P_H:  if (c == CH_H) phase = P_T1; else res = ST_BAD;
                    P_T1: if (c == CH_T) phase = P_T2; else res = ST_BAD;
                    P_T2: if (c == CH_T) phase = P_P; else res = ST_BAD;
                    P_P:  if (c == CH_P) phase = P_SLASH; else res = ST_BAD;
                    P_SLASH: begin
                        if (c == CH_SLASH) begin
                            ver_major = '0;
                            ver_minor = '0;
                            phase     = P_MAJ0;
                        end else res = ST_BAD;
                    end
                    P_MAJ0: begin
                        if (digit_char(c)) begin
                            ver_major = ver_step(ver_major, c);
                            phase     = P_MAJ;
                        end else res = ST_BAD;
                    end
                    P_MAJ: begin
                        if (c == CH_DOT) phase = P_MIN0;
                        else if (digit_char(c)) ver_major = ver_step(ver_major, c);
                        else res = ST_BAD;
                    end
                    P_MIN0: begin
                        if (digit_char(c)) begin
                            ver_minor = ver_step(ver_minor, c);
                            phase     = P_MIN;
                        end else res = ST_BAD;
                    end
                    P_MIN: begin
                        if (c == CH_CR) phase = P_NL1;
                        else if (digit_char(c)) ver_minor = ver_step(ver_minor, c);
                        else res = ST_BAD;
                    end
                    P_NL1: if (c == CH_LF) phase = P_LSTART; else res = ST_BAD;
                    P_LSTART: begin
                        if (c == CH_CR) begin
                            phase = P_NL3;
                        end else if (any_hdr && (c == CH_SP || c == CH_HT)) begin
                            phase = P_LWS;
                        end else if (!tok_char(c)) begin
                            res = ST_BAD;
                        end else begin
                            any_hdr  = 1;
                            in_len   = 0;
                            name_idx = 0;
                            name_ok  = 1;
                            name_step(c);
                            phase = P_HNAME;
                            cls   = CLS_HNAME;
                            hb    = 1;
                        end
                    end
                    P_LWS: begin
                        if (c == CH_CR) begin
                            phase = P_NL2;
                        end else if (c != CH_SP && c != CH_HT) begin
                            if (ctl_char(c)) res = ST_BAD;
                            else begin
                                phase = P_HVAL;
                                value_step(c);
                                cls = CLS_HVAL;
                            end
                        end
                    end
                    P_HNAME: begin
                        if (c == CH_COLON) begin
                            // only the first exact name match is parsed
                            if (name_ok && name_idx == NAME_LEN && !len_found) begin
                                len_found = 1;
                                in_len    = 1;
                                num_state = N_LEAD;
                            end
                            phase = P_SP;
                        end else if (tok_char(c)) begin
                            name_step(c);
                            cls = CLS_HNAME;
                        end else res = ST_BAD;
                    end
                    P_SP: if (c == CH_SP) phase = P_HVAL; else res = ST_BAD;
                    P_HVAL: begin
                        if (c == CH_CR) phase = P_NL2;
                        else if (ctl_char(c)) res = ST_BAD;
                        else begin
                            value_step(c);
                            cls = CLS_HVAL;
                        end
                    end
                    P_NL2: if (c == CH_LF) phase = P_LSTART; else res = ST_BAD;
                    P_NL3: begin
                        if (c != CH_LF || len_neg) res = ST_BAD;
                        else if (len_val != 0) begin
                            body_cnt = '0;
                            phase    = P_BODY;
                        end else res = ST_DONE;
                    end
                    P_BODY: begin
                        cls      = CLS_BODY;
                        body_cnt = body_cnt + 1'b1;
                        if (body_cnt == len_val) res = ST_DONE;
                    end
                    default: res = ST_BAD;
                endcase
                if (res == ST_BAD) begin
                    cls = CLS_DELIM;
                    hb  = 0;
                end
                outcome = res;
            end
            r.status = outcome;
            r.cls    = cls;
            r.hb     = hb;
            r.maj    = ver_major;
            r.min    = ver_minor;
            r.len    = len_val[31:0];
            due_results = {due_results, r};
        endfunction

        function void check_result(logic [71:0] w);
            t_result got, want;
            got.status = w[1:0];
            got.cls    = w[4:2];
            got.hb     = w[5];
            got.maj    = w[21:6];
            got.min    = w[37:22];
            got.len    = w[69:38];
            if (due_results.size() == 0) begin
                if (errors < SHOW_MAX)
                    $display("unexpected result word %h", w);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (got.status !== want.status || got.cls !== want.cls || got.hb !== want.hb ||
                got.maj !== want.maj || got.min !== want.min || got.len !== want.len) begin
                if (errors < SHOW_MAX) begin
                    $display("mismatch: expected st %0d cls %0d hb %0d maj %0d min %0d len %0d",
                             want.status, want.cls, want.hb, want.maj, want.min, want.len);
                    $display("          actual   st %0d cls %0d hb %0d maj %0d min %0d len %0d",
                             got.status, got.cls, got.hb, got.maj, got.min, got.len);
                end
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic [0:0]  s_axis_tuser;   // [0] restart
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;   // status, byte_class, header_begin, version_major,
                                 // version_minor, body_length, zero pad

    request_scoreboard book = new();
    logic [7:0]        msg[$];
    int                bytes_sent = 0;
    int                send_idle  = 16;
    int                recv_idle  = 68;
    int                cycles     = 0;

    http_request_parser_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            book.check_result(m_axis_tdata);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] b, input logic rs);
        if (bytes_sent < ITEMS / 3) begin
            send_idle = 16;
            recv_idle = 68;
        end else if (bytes_sent < 2 * ITEMS / 3) begin
            send_idle = 68;
            recv_idle = 16;
        end else begin
            send_idle = 0;
            recv_idle = 0;
        end
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= rs;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        book.note_byte(b, rs);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_msg(input bit lead_restart);
        foreach (msg[i])
            send_byte(msg[i], (i == 0) ? lead_restart : ($urandom_range(199) == 0));
    endtask

    task automatic add_byte(input logic [7:0] b);
        msg = {msg, b};
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    task automatic push_digits(input int n);
        repeat (n) add_byte(CH_0 + 8'($urandom_range(9)));
    endtask

    function automatic logic [7:0] rand_token();
        logic [7:0] c;
        do c = 8'($urandom_range(33, 126)); while (!request_scoreboard::tok_char(c));
        return c;
    endfunction

    function automatic logic [7:0] rand_text_byte(input bit no_space);
        logic [7:0] c;
        do c = 8'($urandom_range(32, 255));
        while (request_scoreboard::ctl_char(c) || (no_space && c == CH_SP));
        return c;
    endfunction

    // one request line, a few headers, blank line and body; sometimes mangled
    task automatic build_request();
        int         k, n, p, num, body_n;
        bit         is_cl, cl_seen;
        string      nm, big;
        logic [7:0] vq[$];
        msg.delete();
        body_n  = 0;
        cl_seen = 0;
        if ($urandom_range(19) == 0) begin
            repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
            return;
        end
        repeat ($urandom_range(1, 5)) add_byte(rand_token());
        add_byte(CH_SP);
        repeat ($urandom_range(0, 4)) add_byte(rand_text_byte(1));
        add_byte(CH_SP);
        push_text("HTTP/");
        push_digits(($urandom_range(7) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 2));
        add_byte(CH_DOT);
        push_digits(($urandom_range(7) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 2));
        add_byte(CH_CR);
        add_byte(CH_LF);
        repeat ($urandom_range(0, 4)) begin
            k     = $urandom_range(9);
            is_cl = (k < 4);
            vq.delete();
            if (k <= 4) begin
                nm = "Content-Length";
                if (k == 4) begin
                    case ($urandom_range(2))
                        0: begin
                            p = $urandom_range(0, NAME_LEN - 1);
                            nm[p] = nm[p] ^ 8'h20;
                        end
                        1: nm = nm.substr(0, NAME_LEN - 2);
                        default: nm = {nm, "s"};
                    endcase
                end
                push_text(nm);
            end else begin
                repeat ($urandom_range(1, 6)) add_byte(rand_token());
            end
            add_byte(CH_COLON);
            add_byte(CH_SP);
            if (k <= 4) begin
                num = 0;
                repeat ($urandom_range(0, 2)) vq = {vq, CH_SP};
                n = $urandom_range(9);
                if (n == 0) vq = {vq, CH_PLUS};
                else if (n == 1) vq = {vq, CH_MINUS};
                k = $urandom_range(9);
                if (k < 7) begin
                    num = $urandom_range(0, 9);
                    if (k == 6) vq = {vq, CH_0};
                    vq = {vq, CH_0 + 8'(num)};
                end else if (k < 9) begin
                    num = -1;
                    case ($urandom_range(2))
                        0: big = "4294967295";
                        1: big = "4294967296";
                        default: big = "99999999999";
                    endcase
                    for (int i = 0; i < big.len(); i++) vq = {vq, big[i]};
                end
                if ($urandom_range(3) == 0) begin
                    vq = {vq, rand_text_byte(0)};
                    vq = {vq, CH_0 + 8'($urandom_range(9))};
                end
                if (is_cl && !cl_seen) begin
                    cl_seen = 1;
                    body_n  = (n == 1) ? 0 : num;
                end
            end else begin
                repeat ($urandom_range(0, 6)) vq = {vq, rand_text_byte(0)};
            end
            // folded continuation line somewhere in the value
            p = ($urandom_range(4) == 0) ? $urandom_range(0, vq.size()) : -1;
            for (int i = 0; i <= vq.size(); i++) begin
                if (i == p) begin
                    add_byte(CH_CR);
                    add_byte(CH_LF);
                    add_byte($urandom_range(1) ? CH_SP : CH_HT);
                    if ($urandom_range(1)) add_byte(CH_HT);
                end
                if (i < vq.size()) add_byte(vq[i]);
            end
            add_byte(CH_CR);
            add_byte(CH_LF);
        end
        add_byte(CH_CR);
        add_byte(CH_LF);
        n = (body_n >= 0) ? body_n + $urandom_range(0, 2) : $urandom_range(0, 5);
        repeat (n) add_byte(8'($urandom));
        if ($urandom_range(5) == 0)
            msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom);
        if ($urandom_range(9) == 0) begin
            n = $urandom_range(1, msg.size());
            while (msg.size() > n) void'(msg.pop_back());
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // control byte and high byte at method start, then a minimal request
        // followed by a byte that must leave the outcome alone
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        msg.delete();
        push_text("G / HTTP/1.1");
        add_byte(CH_CR);
        add_byte(CH_LF);
        add_byte(CH_CR);
        add_byte(CH_LF);
        send_msg(1'b1);
        send_byte(CH_DEL, 1'b0);

        while (bytes_sent < ITEMS) begin
            build_request();
            send_msg($urandom_range(15) != 0);
        end
        s_axis_tvalid <= 1'b0;

        while (book.due_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (book.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
